// ----- src/img3v_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// img3v_pkg
// Shared types and constants for the IMG3 image header validator.
// ----------------------------------------------------------------------------
package img3v_pkg;

   localparam int DEFAULT_LENGTH_WIDTH = 33;
   localparam int ROOT_LEN             = 20;
   localparam int TAG_HDR_LEN          = 12;
   localparam int RSP_DATA_W           = 152;

   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h33, 8'h67, 8'h6D, 8'h49};

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_SHORT     = 4'd1,
      ST_MAGIC     = 4'd2,
      ST_BODY      = 4'd3,
      ST_SIGAREA   = 4'd4,
      ST_FULLSIZE  = 4'd5,
      ST_TAGHDR    = 4'd6,
      ST_TAGSIZE   = 4'd7,
      ST_TAGPAST   = 4'd8,
      ST_CHAINEND  = 4'd9,
      ST_SHORTREAD = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      SETTLE_ARM,
      SETTLE_END,
      SETTLE_TAGHDR,
      SETTLE_CHAINEND
   } settle_type;

endpackage

// ----- src/img3_image_validator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// img3_image_validator_top
// Checks the root header and tag chain of an IMG3 image streamed one byte per
// request, and returns one status response on the byte that carries tlast.
// rsp_tvalid is registered: the last byte passes the input register, then the
// response register. Throughput: one byte per cycle, set by the single pass
// of the header and tag check logic between the two registers; a last byte
// waits in the input register while a response is held.
// Reset (synchronous, active high) clears the stream state, both register
// stages and image_length.
// ----------------------------------------------------------------------------
module img3_image_validator_top
   import img3v_pkg::*;
#(
   parameter int LENGTH_WIDTH = DEFAULT_LENGTH_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] data_byte
   input  logic                    req_tlast,   // last_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [3:0] status, [35:4] ident_word, [67:36] full_size, [99:68] body_size,
   // [131:100] signed_area, [147:132] tag_count, [151:148] zero
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_we,
   input  logic [LENGTH_WIDTH-1:0] csr_wdata
);

   localparam int LW    = LENGTH_WIDTH;
   localparam int CMP_W = ((LW > 33) ? LW : 33) + 1;
   localparam logic [LW-1:0] OFFSET_MAX = {LW{1'b1}};

   logic [LW-1:0]    image_length_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   logic [LW-1:0]    byte_offset_ff,    byte_offset_in;
   logic [LW-1:0]    next_tag_start_ff, next_tag_start_in;
   logic [31:0]      full_ff,           full_in;
   logic [31:0]      body_ff,           body_in;
   logic [31:0]      sig_ff,            sig_in;
   logic [31:0]      ident_ff,          ident_in;
   logic [3:0]       tag_index_ff,      tag_index_in;
   logic [31:0]      tag_total_ff,      tag_total_in;
   logic [31:0]      tag_data_ff,       tag_data_in;
   status_type       first_error_ff,    first_error_in;
   logic [15:0]      tags_seen_ff,      tags_seen_in;
   logic             in_tag_hdr_ff,     in_tag_hdr_in;

   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   status_type       status_in;
   logic             advance;

   function automatic settle_type settle_f(input logic [CMP_W-1:0] pos,
                                           input logic [CMP_W-1:0] end_pos,
                                           input logic [CMP_W-1:0] lenv);
      settle_type r;
      if (pos < end_pos) begin
         if (pos + CMP_W'(TAG_HDR_LEN) > lenv) r = SETTLE_TAGHDR;
         else r = SETTLE_ARM;
      end else begin
         if (pos != end_pos) r = SETTLE_CHAINEND;
         else r = SETTLE_END;
      end
      return r;
   endfunction

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic [LW-1:0]    idx;
      logic [CMP_W-1:0] lenv;
      logic [CMP_W-1:0] end_pos;
      logic [CMP_W-1:0] pos;
      logic [4:0]       k;
      logic [3:0]       j;
      settle_type       st;

      idx     = byte_offset_ff;
      lenv    = CMP_W'(image_length_ff);
      byte_offset_in    = byte_offset_ff;
      next_tag_start_in = next_tag_start_ff;
      full_in           = full_ff;
      body_in           = body_ff;
      sig_in            = sig_ff;
      ident_in          = ident_ff;
      tag_index_in      = tag_index_ff;
      tag_total_in      = tag_total_ff;
      tag_data_in       = tag_data_ff;
      first_error_in    = first_error_ff;
      tags_seen_in      = tags_seen_ff;
      in_tag_hdr_in     = in_tag_hdr_ff;
      k       = idx[4:0];
      j       = tag_index_ff;
      pos     = '0;
      st      = SETTLE_END;
      end_pos = CMP_W'(body_ff) + CMP_W'(ROOT_LEN);

      if (first_error_in == ST_OK && lenv < CMP_W'(ROOT_LEN)) begin
         first_error_in = ST_SHORT;
         in_tag_hdr_in  = 1'b0;
      end

      if (idx < image_length_ff) begin
         if (idx < LW'(ROOT_LEN)) begin
            unique case (k[4:2])
               3'd0: begin
                  if (first_error_in == ST_OK && in_byte_ff != MAGIC_BYTES[k[1:0]]) begin
                     first_error_in = ST_MAGIC;
                     in_tag_hdr_in  = 1'b0;
                  end
               end
               3'd1: full_in[8*k[1:0] +: 8]  = in_byte_ff;
               3'd2: body_in[8*k[1:0] +: 8]  = in_byte_ff;
               3'd3: sig_in[8*k[1:0] +: 8]   = in_byte_ff;
               3'd4: ident_in[8*k[1:0] +: 8] = in_byte_ff;
               default: ;
            endcase
            if (k == 5'd19 && first_error_in == ST_OK) begin
               priority if (end_pos > lenv) begin
                  first_error_in = ST_BODY;
                  in_tag_hdr_in  = 1'b0;
               end else if (sig_ff > body_ff) begin
                  first_error_in = ST_SIGAREA;
                  in_tag_hdr_in  = 1'b0;
               end else if (end_pos > CMP_W'(full_ff)) begin
                  first_error_in = ST_FULLSIZE;
                  in_tag_hdr_in  = 1'b0;
               end else begin
                  pos = CMP_W'(ROOT_LEN);
                  st  = settle_f(pos, end_pos, lenv);
                  unique case (st)
                     SETTLE_ARM: begin
                        next_tag_start_in = pos[LW-1:0];
                        tag_index_in      = '0;
                        in_tag_hdr_in     = 1'b1;
                     end
                     SETTLE_END: in_tag_hdr_in = 1'b0;
                     SETTLE_TAGHDR: begin
                        first_error_in = ST_TAGHDR;
                        in_tag_hdr_in  = 1'b0;
                     end
                     SETTLE_CHAINEND: begin
                        first_error_in = ST_CHAINEND;
                        in_tag_hdr_in  = 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
         end else if (first_error_in == ST_OK && in_tag_hdr_ff &&
                      idx == next_tag_start_ff + LW'(tag_index_ff)) begin
            if (j == 4'd0) begin
               tag_total_in = '0;
               tag_data_in  = '0;
            end
            unique case (j[3:2])
               2'd1:    tag_total_in[8*j[1:0] +: 8] = in_byte_ff;
               2'd2:    tag_data_in[8*j[1:0] +: 8]  = in_byte_ff;
               default: ;
            endcase
            if (j >= 4'd11) begin
               if (tags_seen_ff != 16'hFFFF) tags_seen_in = tags_seen_ff + 16'd1;
               pos = CMP_W'(next_tag_start_ff) + CMP_W'(tag_total_in);
               priority if (CMP_W'(tag_total_in) <
                            CMP_W'(tag_data_in) + CMP_W'(TAG_HDR_LEN)) begin
                  first_error_in = ST_TAGSIZE;
                  in_tag_hdr_in  = 1'b0;
               end else if (pos > lenv) begin
                  first_error_in = ST_TAGPAST;
                  in_tag_hdr_in  = 1'b0;
               end else begin
                  st = settle_f(pos, end_pos, lenv);
                  unique case (st)
                     SETTLE_ARM: begin
                        next_tag_start_in = pos[LW-1:0];
                        tag_index_in      = '0;
                        in_tag_hdr_in     = 1'b1;
                     end
                     SETTLE_END: in_tag_hdr_in = 1'b0;
                     SETTLE_TAGHDR: begin
                        first_error_in = ST_TAGHDR;
                        in_tag_hdr_in  = 1'b0;
                     end
                     SETTLE_CHAINEND: begin
                        first_error_in = ST_CHAINEND;
                        in_tag_hdr_in  = 1'b0;
                     end
                     default: ;
                  endcase
               end
            end else begin
               tag_index_in = j + 4'd1;
            end
         end
      end

      if (byte_offset_ff != OFFSET_MAX) byte_offset_in = byte_offset_ff + LW'(1);

      status_in = first_error_in;
      if (status_in == ST_OK) begin
         if ((CMP_W'(idx) + CMP_W'(1) < lenv) || in_tag_hdr_in || idx < LW'(19))
            status_in = ST_SHORTREAD;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= {4'b0000, tags_seen_in, sig_in, body_in, full_in, ident_in,
                         status_in};
      end
      if (reset) begin
         image_length_ff   <= '0;
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         byte_offset_ff    <= '0;
         next_tag_start_ff <= LW'(ROOT_LEN);
         full_ff           <= '0;
         body_ff           <= '0;
         sig_ff            <= '0;
         ident_ff          <= '0;
         tag_index_ff      <= '0;
         tag_total_ff      <= '0;
         tag_data_ff       <= '0;
         first_error_ff    <= ST_OK;
         tags_seen_ff      <= '0;
         in_tag_hdr_ff     <= 1'b0;
      end else begin
         if (csr_we) image_length_ff <= csr_wdata;

         if (req_tvalid && req_tready) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;

         if (advance && in_last_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (advance) begin
            if (in_last_ff) begin
               byte_offset_ff    <= '0;
               next_tag_start_ff <= LW'(ROOT_LEN);
               full_ff           <= '0;
               body_ff           <= '0;
               sig_ff            <= '0;
               ident_ff          <= '0;
               tag_index_ff      <= '0;
               tag_total_ff      <= '0;
               tag_data_ff       <= '0;
               first_error_ff    <= ST_OK;
               tags_seen_ff      <= '0;
               in_tag_hdr_ff     <= 1'b0;
            end else begin
               byte_offset_ff    <= byte_offset_in;
               next_tag_start_ff <= next_tag_start_in;
               full_ff           <= full_in;
               body_ff           <= body_in;
               sig_ff            <= sig_in;
               ident_ff          <= ident_in;
               tag_index_ff      <= tag_index_in;
               tag_total_ff      <= tag_total_in;
               tag_data_ff       <= tag_data_in;
               first_error_ff    <= first_error_in;
               tags_seen_ff      <= tags_seen_in;
               in_tag_hdr_ff     <= in_tag_hdr_in;
            end
         end
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (byte_offset_ff == '0 && first_error_ff == ST_OK &&
                                   tags_seen_ff == '0 && !in_tag_hdr_ff))
      else $error("stream state not cleared after last byte");

   a_tag_index_range: assert property (@(posedge clock) disable iff (reset)
      in_tag_hdr_ff |-> (tag_index_ff <= 4'd11 && first_error_ff == ST_OK))
      else $error("tag header walk out of range");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (first_error_ff != ST_OK && !(advance && in_last_ff))
         |=> (first_error_ff == $past(first_error_ff)))
      else $error("first error overwritten");

   a_rsp_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[3:0] <= ST_SHORTREAD))
      else $error("response status code out of range");

endmodule
